### hdl/cap_pkg.sv
// ----------------------------------------------------------------------------
// cap_pkg
// Shared constants, register indexes and types for the cave automaton pass.
// ----------------------------------------------------------------------------
package cap_pkg;

    localparam int CFG_W   = 9;
    localparam int IDX_W   = 3;
    localparam int WALL_W  = 4;
    localparam int OPEN_W  = 5;
    localparam int WIN_N   = 5;
    localparam int LINE_W  = WIN_N - 1;
    localparam int BYTE_W  = 8;

    localparam int DEF_MAX_ROW_LENGTH = 256;
    localparam int DEF_MAX_ROW_COUNT  = 256;

    localparam logic [CFG_W-1:0]  RST_ROW_LENGTH = 9'd256;
    localparam logic [CFG_W-1:0]  RST_ROW_COUNT  = 9'd256;
    localparam logic              RST_USE_SPARSE = 1'b1;
    localparam logic [WALL_W-1:0] RST_WALL_THR   = 4'd5;
    localparam logic [OPEN_W-1:0] RST_OPEN_THR   = 5'd2;

    typedef enum logic [IDX_W-1:0] {
        REG_ROW_LENGTH = 3'd0,
        REG_ROW_COUNT  = 3'd1,
        REG_USE_SPARSE = 3'd2,
        REG_WALL_THR   = 3'd3,
        REG_OPEN_THR   = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic              use_sparse;
        logic [WALL_W-1:0] wall_thr;
        logic [OPEN_W-1:0] open_thr;
    } cap_rule_t;

    // bit j of each field: offset j-2 from the center row / column
    typedef struct packed {
        logic [WIN_N-1:0] row_ok;
        logic [WIN_N-1:0] col_ok;
    } cap_mask_t;

endpackage

### hdl/cap_line_window.sv
// ----------------------------------------------------------------------------
// cap_line_window
// Column line store, 5x5 window shift register and wall rule.
// ----------------------------------------------------------------------------
module cap_line_window #(
    parameter int MAX_ROW_LENGTH = cap_pkg::DEF_MAX_ROW_LENGTH,
    localparam int COL_W = $clog2(MAX_ROW_LENGTH)
) (
    input  logic                clk,
    input  logic                load,
    input  logic [COL_W-1:0]    load_col,
    input  logic                load_cell,
    input  logic                adv,
    input  cap_pkg::cap_mask_t  mask,
    input  cap_pkg::cap_rule_t  rule,
    output logic                wall
);

    logic [cap_pkg::LINE_W-1:0] mem [MAX_ROW_LENGTH];

    logic [COL_W-1:0]           col_reg;
    logic                       cell_reg;
    logic [cap_pkg::LINE_W-1:0] word_reg;
    logic [cap_pkg::WIN_N-1:0]  win_reg [cap_pkg::WIN_N-1];

    logic [cap_pkg::WIN_N-1:0]  new_col;
    logic [cap_pkg::LINE_W-1:0] new_word;
    logic [cap_pkg::WIN_N-1:0]  col_vec [cap_pkg::WIN_N];
    logic [cap_pkg::WIN_N*cap_pkg::WIN_N-1:0] bits5;
    logic [8:0]                 bits3;
    logic [4:0]                 w5;
    logic [3:0]                 w3;

    // column word: bit i holds row (current - 4 + i)
    assign new_col  = {cell_reg, word_reg};
    assign new_word = new_col[cap_pkg::WIN_N-1:1];

    always_comb
    begin
        col_vec[cap_pkg::WIN_N-1] = new_col;
        for (int j = 0; j < cap_pkg::WIN_N - 1; j++)
        begin
            col_vec[j] = win_reg[cap_pkg::WIN_N-2-j];
        end
        for (int j = 0; j < cap_pkg::WIN_N; j++)
        begin
            bits5[j*cap_pkg::WIN_N +: cap_pkg::WIN_N] =
                mask.col_ok[j] ? (col_vec[j] & mask.row_ok) : '0;
        end
        for (int j = 0; j < 3; j++)
        begin
            bits3[j*3 +: 3] = bits5[(j+1)*cap_pkg::WIN_N + 1 +: 3];
        end
    end

    assign w5   = 5'($countones(bits5));
    assign w3   = 4'($countones(bits3));
    assign wall = (w3 >= rule.wall_thr) || (rule.use_sparse && (w5 <= rule.open_thr));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mem[col_reg] <= new_word;
        end
        if (load)
        begin
            col_reg  <= load_col;
            cell_reg <= load_cell;
            // bypass the word written back at this same edge
            if (adv && (col_reg == load_col))
            begin
                word_reg <= new_word;
            end
            else
            begin
                word_reg <= mem[load_col];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            win_reg[0] <= new_col;
            for (int i = 1; i < cap_pkg::WIN_N - 1; i++)
            begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

endmodule

### hdl/cave_automaton_pass.sv
// ----------------------------------------------------------------------------
// cave_automaton_pass
// One smoothing pass of the cave cellular automaton over a raster grid.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one grid cell per word, tdata[0] = 1 wall, 0 floor. After each
//   frame of row_length*row_count cells the feeder sends 2*row_length+2
//   padding words; their values are ignored.
//   m_axis: one result per grid cell in raster order, tdata[0] = new cell,
//   tlast on the final cell of the frame. The first 2*row_length+2 words of
//   a frame produce nothing; every later word up to the frame end produces
//   exactly one result.
//   cfg: write-only registers (index 0 row_length, 1 row_count,
//   2 use_sparse_rule, 3 wall_threshold, 4 open_threshold); cfg_ready is
//   always high. Write only while no result is outstanding.
// Throughput: one word per cycle unless m_axis stalls, set by the dual-port
// column store (one read and one write per cycle) and the 25-bit window count.
// Path: the input stage registers each word, the result register its result.
// Reset: registers return to 256/256/1/5/2, counters to frame start. The
// line store is not cleared; rows above the grid are masked instead.
// Stall: with m_axis stalled one more word is taken into the input stage,
// then s_axis_tready drops until the held result is taken.
// ----------------------------------------------------------------------------
module cave_automaton_pass #(
    parameter int MAX_ROW_LENGTH = cap_pkg::DEF_MAX_ROW_LENGTH,
    parameter int MAX_ROW_COUNT  = cap_pkg::DEF_MAX_ROW_COUNT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [cap_pkg::BYTE_W-1:0]  s_axis_tdata,   // [0] cell_req
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [cap_pkg::BYTE_W-1:0]  m_axis_tdata,   // [0] new_cell
    output logic                        m_axis_tlast,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cap_pkg::IDX_W-1:0]   cfg_index,
    input  logic [cap_pkg::CFG_W-1:0]   cfg_data
);

    localparam int COL_W = $clog2(MAX_ROW_LENGTH);
    localparam int KW    = $clog2(MAX_ROW_LENGTH * MAX_ROW_COUNT + 2 * MAX_ROW_LENGTH + 3);
    localparam int RW    = $clog2(MAX_ROW_COUNT + 1);
    localparam int NW    = ((COL_W > cap_pkg::CFG_W) ? COL_W : cap_pkg::CFG_W) + 2;
    localparam int MW    = ((RW > cap_pkg::CFG_W) ? RW : cap_pkg::CFG_W) + 2;
    localparam int PW    = 2 * cap_pkg::CFG_W;

    function automatic logic [cap_pkg::CFG_W-1:0] clamp_len(
        input logic [cap_pkg::CFG_W-1:0] v,
        input int                        max_len
    );
        logic [cap_pkg::CFG_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = cap_pkg::CFG_W'(1);
        end
        else if (int'(v) > max_len)
        begin
            r = cap_pkg::CFG_W'(max_len);
        end
        return r;
    endfunction

    // configuration
    logic [cap_pkg::CFG_W-1:0]  row_length_reg;
    logic [cap_pkg::CFG_W-1:0]  row_count_reg;
    cap_pkg::cap_rule_t         rule_reg;

    // frame counters
    logic [KW-1:0]              k_reg,     k_next;
    logic [COL_W-1:0]           in_col_reg, in_col_next;
    logic [COL_W-1:0]           ocol_reg,  ocol_next;
    logic [RW-1:0]              orow_reg,  orow_next;

    // input stage
    logic                       s1_valid_reg;
    logic                       s1_prod_reg;
    logic                       s1_last_reg;
    cap_pkg::cap_mask_t         s1_mask_reg;

    // result register
    logic                       out_valid_reg;
    logic                       out_cell_reg;
    logic                       out_last_reg;

    logic [cap_pkg::CFG_W-1:0]  len_eff;
    logic [cap_pkg::CFG_W-1:0]  cnt_eff;
    logic [KW-1:0]              cells;
    logic [KW-1:0]              lag;
    logic [KW-1:0]              total;
    logic                       accept;
    logic                       adv;
    logic                       in_grid;
    logic                       produce;
    logic                       frame_end;
    logic                       col_wrap;
    logic                       ocol_wrap;
    logic                       load_cell;
    cap_pkg::cap_mask_t         mask;
    logic                       wall;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg      <= cap_pkg::RST_ROW_LENGTH;
            row_count_reg       <= cap_pkg::RST_ROW_COUNT;
            rule_reg.use_sparse <= cap_pkg::RST_USE_SPARSE;
            rule_reg.wall_thr   <= cap_pkg::RST_WALL_THR;
            rule_reg.open_thr   <= cap_pkg::RST_OPEN_THR;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                cap_pkg::REG_ROW_LENGTH: row_length_reg      <= cfg_data;
                cap_pkg::REG_ROW_COUNT:  row_count_reg       <= cfg_data;
                cap_pkg::REG_USE_SPARSE: rule_reg.use_sparse <= cfg_data[0];
                cap_pkg::REG_WALL_THR:   rule_reg.wall_thr   <= cfg_data[cap_pkg::WALL_W-1:0];
                cap_pkg::REG_OPEN_THR:   rule_reg.open_thr   <= cfg_data[cap_pkg::OPEN_W-1:0];
                default: ;
            endcase
        end
    end

    // frame geometry and position of the current word
    always_comb
    begin
        len_eff   = clamp_len(row_length_reg, MAX_ROW_LENGTH);
        cnt_eff   = clamp_len(row_count_reg, MAX_ROW_COUNT);
        cells     = KW'(PW'(len_eff) * PW'(cnt_eff));
        lag       = KW'({len_eff, 1'b0}) + KW'(2);
        total     = cells + lag;
        in_grid   = k_reg < cells;
        produce   = (k_reg >= lag) && (k_reg < total);
        frame_end = ((KW+1)'(k_reg) + (KW+1)'(1)) >= (KW+1)'(total);
        col_wrap  = (NW'(in_col_reg) + NW'(1)) >= NW'(len_eff);
        ocol_wrap = (NW'(ocol_reg) + NW'(1)) >= NW'(len_eff);
        load_cell = in_grid & s_axis_tdata[0];

        mask.row_ok[0] = orow_reg >= RW'(2);
        mask.row_ok[1] = orow_reg >= RW'(1);
        mask.row_ok[2] = 1'b1;
        mask.row_ok[3] = (MW'(orow_reg) + MW'(1)) < MW'(cnt_eff);
        mask.row_ok[4] = (MW'(orow_reg) + MW'(2)) < MW'(cnt_eff);
        mask.col_ok[0] = ocol_reg >= COL_W'(2);
        mask.col_ok[1] = ocol_reg >= COL_W'(1);
        mask.col_ok[2] = 1'b1;
        mask.col_ok[3] = (NW'(ocol_reg) + NW'(1)) < NW'(len_eff);
        mask.col_ok[4] = (NW'(ocol_reg) + NW'(2)) < NW'(len_eff);

        k_next      = k_reg;
        in_col_next = in_col_reg;
        ocol_next   = ocol_reg;
        orow_next   = orow_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                k_next      = '0;
                in_col_next = '0;
                ocol_next   = '0;
                orow_next   = '0;
            end
            else
            begin
                k_next      = k_reg + KW'(1);
                in_col_next = col_wrap ? '0 : (in_col_reg + COL_W'(1));
                if (produce)
                begin
                    if (ocol_wrap)
                    begin
                        ocol_next = '0;
                        orow_next = orow_reg + RW'(1);
                    end
                    else
                    begin
                        ocol_next = ocol_reg + COL_W'(1);
                    end
                end
            end
        end
    end

    assign adv           = s1_valid_reg && (!s1_prod_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg        <= '0;
            in_col_reg   <= '0;
            ocol_reg     <= '0;
            orow_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s1_prod_reg  <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            k_reg      <= k_next;
            in_col_reg <= in_col_next;
            ocol_reg   <= ocol_next;
            orow_reg   <= orow_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_prod_reg  <= produce;
                s1_last_reg  <= produce && frame_end;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mask_reg <= mask;
        end
    end

    cap_line_window #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
    ) u_window (
        .clk       (clk),
        .load      (accept),
        .load_col  (in_col_reg),
        .load_cell (load_cell),
        .adv       (adv),
        .mask      (s1_mask_reg),
        .rule      (rule_reg),
        .wall      (wall)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && s1_prod_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_prod_reg)
        begin
            out_cell_reg <= wall;
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(cap_pkg::BYTE_W-1){1'b0}}, out_cell_reg};
    assign m_axis_tlast  = out_last_reg;

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && s1_prod_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a held result");

    a_last_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg) |-> s1_prod_reg)
        else $error("frame end marked on a word without result");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_end) |=> ((k_reg == '0) && (in_col_reg == '0) && (orow_reg == '0)))
        else $error("counters not cleared after frame end");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_prod_reg))
        else $error("result appeared without a producing word");

endmodule
